// ===== design/srt_pkg.sv =====
`timescale 1ns / 1ps

package srt_pkg;

  // Command codes carried on the command port.
  typedef enum logic [3:0] {
    CMD_CLEAR       = 4'd0,
    CMD_APPEND      = 4'd1,
    CMD_MARK_USED   = 4'd2,
    CMD_MARK_UNUSED = 4'd3,
    CMD_FIND_NUMBER = 4'd4,
    CMD_FIND_ZONE   = 4'd5,
    CMD_FROM_MASK   = 4'd6,
    CMD_CLEAR_USED  = 4'd7,
    CMD_COLLECT     = 4'd8
  } cmd_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // Request token that walks the slot chain, one cell per cycle.
  typedef struct packed {
    logic        active;
    cmd_t        cmd;
    logic [15:0] number;
    logic [31:0] zone;
    logic [15:0] imask;
    logic        hit;
    logic [3:0]  idx;
    logic [15:0] sbit;
    logic [15:0] umask;
  } token_t;

  // Per-cell control from the controller.
  typedef struct packed {
    logic valid;      // slot has been written (position below the count)
    logic tail;       // slot is the next one to be appended
    logic clr_all;    // clear the used flag unconditionally
    logic clr_valid;  // clear the used flag if the slot is valid
  } cell_ctl_t;

endpackage

// ===== design/srt_cell.sv =====
`timescale 1ns / 1ps

module srt_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  srt_pkg::cell_ctl_t ctl,
  input  srt_pkg::token_t   tok_in,
  output srt_pkg::token_t   tok_out
);

  localparam logic        LOW = (IDX < 16);
  localparam logic [3:0]  POS = 4'(IDX % 16);
  localparam logic [15:0] BIT = LOW ? (16'd1 << POS) : 16'd0;

  logic [15:0]     number;
  logic [31:0]     zone;
  logic            used;
  logic            used_next;
  logic            wr;
  srt_pkg::token_t tok_next;

  // Act on the request passing through this slot.
  always_comb begin
    tok_next  = tok_in;
    used_next = used;
    wr        = 1'b0;
    if (ctl.clr_all || (ctl.clr_valid && ctl.valid)) begin
      used_next = 1'b0;
    end
    if (tok_in.active) begin
      case (tok_in.cmd)
        srt_pkg::CMD_APPEND: begin
          if (ctl.tail) begin
            wr            = 1'b1;
            used_next     = 1'b0;
            tok_next.hit  = 1'b1;
            tok_next.idx  = POS;
            tok_next.sbit = BIT;
          end
        end
        srt_pkg::CMD_MARK_USED, srt_pkg::CMD_MARK_UNUSED: begin
          if (ctl.valid && !tok_in.hit && number == tok_in.number) begin
            used_next     = (tok_in.cmd == srt_pkg::CMD_MARK_USED);
            tok_next.hit  = 1'b1;
            tok_next.idx  = POS;
            tok_next.sbit = BIT;
          end
        end
        srt_pkg::CMD_FIND_NUMBER: begin
          if (ctl.valid && !tok_in.hit && number == tok_in.number) begin
            tok_next.hit  = 1'b1;
            tok_next.idx  = POS;
            tok_next.sbit = BIT;
          end
        end
        srt_pkg::CMD_FIND_ZONE: begin
          if (ctl.valid && !tok_in.hit && (zone & tok_in.zone) != 32'd0) begin
            tok_next.hit  = 1'b1;
            tok_next.idx  = POS;
            tok_next.sbit = BIT;
          end
        end
        srt_pkg::CMD_FROM_MASK: begin
          // Later positions override, so the highest set bit wins.
          if (ctl.valid && LOW && tok_in.imask[POS]) begin
            tok_next.hit  = 1'b1;
            tok_next.idx  = POS;
            tok_next.sbit = BIT;
          end
        end
        srt_pkg::CMD_COLLECT: begin
          if (ctl.valid && used) begin
            tok_next.umask = tok_in.umask | BIT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Used flag and the outgoing token.
  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= 1'b0;
      tok_out <= '0;
    end else begin
      used    <= used_next;
      tok_out <= tok_next;
    end
  end

  // Slot contents, written on append only.
  always_ff @(posedge clk) begin
    if (wr) begin
      number <= tok_in.number;
      zone   <= tok_in.zone;
    end
  end

endmodule

// ===== design/slot_registry_table.sv =====
`timescale 1ns / 1ps
// Clear, clear used, unknown commands and a refused append are answered directly from the
// controller; chain commands walk a token through the launch register and every slot cell.
// One request at a time: in_stall stays high until the result has moved into the output
// register, so a new request is taken only after the last one is through.
// Reset clears the slot count, all used flags and the pending-change mark; slot numbers
// and zone masks are left undefined until appended.

module slot_registry_table #(
  parameter int MAX_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  command,
  input  logic [15:0] slot_number,
  input  logic [31:0] zone_mask,
  input  logic [15:0] index_mask,
  input  logic        reload_mode,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [3:0]  slot_index,
  output logic [15:0] slot_bit,
  output logic [15:0] used_mask,
  output logic [1:0]  change_pending,
  output logic        table_full
);

  localparam int CW = $clog2(MAX_SLOTS + 1);

  srt_pkg::state_t    state;
  srt_pkg::state_t    state_next;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [1:0]         pending;
  logic [1:0]         pending_next;
  srt_pkg::token_t    launch;
  srt_pkg::token_t    tok [MAX_SLOTS+1];
  srt_pkg::cell_ctl_t ctl [MAX_SLOTS];
  srt_pkg::cmd_t      cmd_in;
  logic               accept;
  logic               is_full;
  logic               do_launch;
  logic               scan_done;
  logic               out_free;
  logic               clr_all;
  logic               clr_valid;

  logic        res_found, res_found_next;
  logic [3:0]  res_idx, res_idx_next;
  logic [15:0] res_bit, res_bit_next;
  logic [15:0] res_umask, res_umask_next;
  logic [1:0]  res_cp, res_cp_next;
  logic        res_full, res_full_next;
  logic        res_load;

  assign cmd_in    = srt_pkg::cmd_t'(command);
  assign in_stall  = (state != srt_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign is_full   = (count == CW'(MAX_SLOTS));
  assign scan_done = (state == srt_pkg::ST_SCAN) && tok[MAX_SLOTS].active;
  assign out_free  = !out_valid || !out_stall;
  assign clr_all   = accept && (cmd_in == srt_pkg::CMD_CLEAR);
  assign clr_valid = accept && (cmd_in == srt_pkg::CMD_CLEAR_USED);

  // Slot chain.
  assign tok[0] = launch;
  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    assign ctl[i].valid     = (CW'(i) < count);
    assign ctl[i].tail      = (CW'(i) == count);
    assign ctl[i].clr_all   = clr_all;
    assign ctl[i].clr_valid = clr_valid;

    srt_cell #(
      .IDX(i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl[i]),
      .tok_in (tok[i]),
      .tok_out(tok[i+1])
    );
  end

  // Command decode, chain completion and result staging.
  always_comb begin
    state_next     = state;
    count_next     = count;
    pending_next   = pending;
    do_launch      = 1'b0;
    res_load       = 1'b0;
    res_found_next = 1'b0;
    res_idx_next   = 4'd0;
    res_bit_next   = 16'd0;
    res_umask_next = 16'd0;
    res_cp_next    = pending;
    res_full_next  = 1'b0;
    case (state)
      srt_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd_in)
            srt_pkg::CMD_CLEAR: begin
              count_next   = '0;
              pending_next = 2'd0;
              res_cp_next  = 2'd0;
              res_load     = 1'b1;
              state_next   = srt_pkg::ST_DONE;
            end
            srt_pkg::CMD_CLEAR_USED: begin
              pending_next = {reload_mode, !reload_mode};
              res_cp_next  = {reload_mode, !reload_mode};
              res_load     = 1'b1;
              state_next   = srt_pkg::ST_DONE;
            end
            srt_pkg::CMD_APPEND: begin
              if (is_full) begin
                res_full_next = 1'b1;
                res_load      = 1'b1;
                state_next    = srt_pkg::ST_DONE;
              end else begin
                do_launch  = 1'b1;
                state_next = srt_pkg::ST_SCAN;
              end
            end
            srt_pkg::CMD_MARK_USED, srt_pkg::CMD_MARK_UNUSED, srt_pkg::CMD_FIND_NUMBER,
            srt_pkg::CMD_FIND_ZONE, srt_pkg::CMD_FROM_MASK, srt_pkg::CMD_COLLECT: begin
              do_launch  = 1'b1;
              state_next = srt_pkg::ST_SCAN;
            end
            default: begin
              res_load   = 1'b1;
              state_next = srt_pkg::ST_DONE;
            end
          endcase
        end
      end
      srt_pkg::ST_SCAN: begin
        if (scan_done) begin
          res_load       = 1'b1;
          res_found_next = tok[MAX_SLOTS].hit;
          res_idx_next   = tok[MAX_SLOTS].idx;
          res_bit_next   = tok[MAX_SLOTS].sbit;
          state_next     = srt_pkg::ST_DONE;
          case (tok[MAX_SLOTS].cmd)
            srt_pkg::CMD_APPEND: begin
              if (tok[MAX_SLOTS].hit) begin
                count_next = count + CW'(1);
              end
            end
            srt_pkg::CMD_MARK_USED, srt_pkg::CMD_MARK_UNUSED: begin
              if (tok[MAX_SLOTS].hit) begin
                pending_next = 2'd1;
                res_cp_next  = 2'd1;
              end
            end
            srt_pkg::CMD_COLLECT: begin
              res_umask_next = tok[MAX_SLOTS].umask;
              pending_next   = 2'd0;
            end
            default: begin
            end
          endcase
        end
      end
      srt_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = srt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = srt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers and the launch token.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= srt_pkg::ST_IDLE;
      count         <= '0;
      pending       <= 2'd0;
      launch.active <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      pending       <= pending_next;
      launch.active <= do_launch;
      if (do_launch) begin
        launch.cmd    <= cmd_in;
        launch.number <= slot_number;
        launch.zone   <= zone_mask;
        launch.imask  <= index_mask;
        launch.hit    <= 1'b0;
        launch.idx    <= 4'd0;
        launch.sbit   <= 16'd0;
        launch.umask  <= 16'd0;
      end
      if (state == srt_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Staged result, held until the output register is free.
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_found <= res_found_next;
      res_idx   <= res_idx_next;
      res_bit   <= res_bit_next;
      res_umask <= res_umask_next;
      res_cp    <= res_cp_next;
      res_full  <= res_full_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (state == srt_pkg::ST_DONE && out_free) begin
      found          <= res_found;
      slot_index     <= res_idx;
      slot_bit       <= res_bit;
      used_mask      <= res_umask;
      change_pending <= res_cp;
      table_full     <= res_full;
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import srt_pkg::*;

  localparam int NSLOTS = 16;
  // A code beyond the defined command set; the block must ignore it.
  localparam logic [3:0] CMD_RESERVED = 4'hF;
  localparam int TOTAL_REQUESTS = 1050;
  localparam int HOLD_AT = 300;
  localparam int PAUSE_AT = 650;
  localparam int QUIET_FROM = 900;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [15:0] number;
    logic [31:0] zone;
    logic [15:0] imask;
    logic        mode;
  } registry_req_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  idx;
    logic [15:0] sbit;
    logic [15:0] umask;
    logic [1:0]  pend;
    logic        full;
  } registry_reply_t;

  typedef struct packed {
    registry_req_t   req;
    logic [4:0]      reps;
    logic            typed;
    registry_reply_t reply;
  } directed_row_t;

  localparam registry_reply_t ZERO_REPLY = '0;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  command;
  logic [15:0] slot_number;
  logic [31:0] zone_mask;
  logic [15:0] index_mask;
  logic        reload_mode;
  logic        out_valid;
  logic        out_stall;
  logic        found;
  logic [3:0]  slot_index;
  logic [15:0] slot_bit;
  logic [15:0] used_mask;
  logic [1:0]  change_pending;
  logic        table_full;

  // Predicted registry contents.
  logic [15:0] reg_number [NSLOTS];
  logic        reg_used   [NSLOTS];
  logic [31:0] reg_zone   [NSLOTS];
  int          reg_fill;
  logic [1:0]  reg_pending;

  registry_reply_t expected_replies [$];
  logic [15:0]     appended_numbers [$];
  int              requests_sent;
  int              failures;
  bit              quiet;
  bit              long_hold_req;

  // Directed requests: reset state, field extremes, every command and the corner cases.
  directed_row_t directed_rows [24] = '{
    '{'{CMD_COLLECT,     16'h0000, 32'h0000_0000, 16'h0000, 1'b0}, 5'd1, 1'b1, ZERO_REPLY},
    '{'{CMD_FIND_NUMBER, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0}, 5'd1, 1'b1, ZERO_REPLY},
    '{'{CMD_RESERVED,    16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1}, 5'd1, 1'b1, ZERO_REPLY},
    '{'{CMD_APPEND,      16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 1'b0}, 5'd1, 1'b1,
      '{1'b1, 4'd0, 16'h0001, 16'h0000, 2'd0, 1'b0}},
    '{'{CMD_APPEND,      16'h0000, 32'h0000_0001, 16'h0000, 1'b0}, 5'd1, 1'b1,
      '{1'b1, 4'd1, 16'h0002, 16'h0000, 2'd0, 1'b0}},
    '{'{CMD_MARK_USED,   16'hFFFF, 32'h0000_0000, 16'h0000, 1'b0}, 5'd1, 1'b1,
      '{1'b1, 4'd0, 16'h0001, 16'h0000, 2'd1, 1'b0}},
    '{'{CMD_MARK_UNUSED, 16'h1234, 32'h0000_0000, 16'h0000, 1'b0}, 5'd1, 1'b1,
      '{1'b0, 4'd0, 16'h0000, 16'h0000, 2'd1, 1'b0}},
    '{'{CMD_FIND_ZONE,   16'h0000, 32'h0000_0000, 16'h0000, 1'b0}, 5'd1, 1'b1,
      '{1'b0, 4'd0, 16'h0000, 16'h0000, 2'd1, 1'b0}},
    '{'{CMD_FIND_ZONE,   16'h0000, 32'h0000_0001, 16'h0000, 1'b0}, 5'd1, 1'b0, ZERO_REPLY},
    '{'{CMD_FROM_MASK,   16'h0000, 32'h0000_0000, 16'hFFFF, 1'b0}, 5'd1, 1'b0, ZERO_REPLY},
    '{'{CMD_FROM_MASK,   16'h0000, 32'h0000_0000, 16'hFFFC, 1'b0}, 5'd1, 1'b0, ZERO_REPLY},
    '{'{CMD_COLLECT,     16'h0000, 32'h0000_0000, 16'h0000, 1'b0}, 5'd1, 1'b0, ZERO_REPLY},
    '{'{CMD_CLEAR_USED,  16'h0000, 32'h0000_0000, 16'h0000, 1'b1}, 5'd1, 1'b1,
      '{1'b0, 4'd0, 16'h0000, 16'h0000, 2'd2, 1'b0}},
    '{'{CMD_COLLECT,     16'h0000, 32'h0000_0000, 16'h0000, 1'b0}, 5'd1, 1'b0, ZERO_REPLY},
    '{'{CMD_CLEAR,       16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1}, 5'd1, 1'b1, ZERO_REPLY},
    '{'{CMD_APPEND,      16'h5A5A, 32'h0000_8000, 16'h0000, 1'b0}, 5'd16, 1'b0, ZERO_REPLY},
    '{'{CMD_APPEND,      16'h1111, 32'h0000_0001, 16'h0000, 1'b0}, 5'd1, 1'b1,
      '{1'b0, 4'd0, 16'h0000, 16'h0000, 2'd0, 1'b1}},
    '{'{CMD_MARK_USED,   16'h5A5A, 32'h0000_0000, 16'h0000, 1'b0}, 5'd1, 1'b0, ZERO_REPLY},
    '{'{CMD_MARK_UNUSED, 16'h5A5A, 32'h0000_0000, 16'h0000, 1'b0}, 5'd1, 1'b0, ZERO_REPLY},
    '{'{CMD_FROM_MASK,   16'h0000, 32'h0000_0000, 16'h8000, 1'b0}, 5'd1, 1'b0, ZERO_REPLY},
    '{'{CMD_CLEAR_USED,  16'h0000, 32'h0000_0000, 16'h0000, 1'b0}, 5'd1, 1'b1,
      '{1'b0, 4'd0, 16'h0000, 16'h0000, 2'd1, 1'b0}},
    '{'{CMD_COLLECT,     16'h0000, 32'h0000_0000, 16'h0000, 1'b0}, 5'd1, 1'b1,
      '{1'b0, 4'd0, 16'h0000, 16'h0000, 2'd1, 1'b0}},
    '{'{CMD_FIND_ZONE,   16'h0000, 32'h8000_0000, 16'h0000, 1'b0}, 5'd1, 1'b0, ZERO_REPLY},
    '{'{CMD_CLEAR,       16'h0000, 32'h0000_0000, 16'h0000, 1'b0}, 5'd1, 1'b1, ZERO_REPLY}
  };

  slot_registry_table #(
    .MAX_SLOTS(NSLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .slot_number(slot_number),
    .zone_mask(zone_mask),
    .index_mask(index_mask),
    .reload_mode(reload_mode),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .found(found),
    .slot_index(slot_index),
    .slot_bit(slot_bit),
    .used_mask(used_mask),
    .change_pending(change_pending),
    .table_full(table_full)
  );

  always #5 clk = ~clk;

  // Applies one request to the predicted registry and returns the reply it should give.
  function automatic registry_reply_t registry_apply(input registry_req_t r);
    registry_reply_t y;
    int hit;
    y = '0;
    hit = -1;
    case (r.cmd)
      CMD_CLEAR: begin
        reg_fill = 0;
        reg_pending = 2'd0;
        for (int i = 0; i < NSLOTS; i++) reg_used[i] = 1'b0;
      end
      CMD_APPEND: begin
        if (reg_fill >= NSLOTS) begin
          y.full = 1'b1;
        end else begin
          reg_number[reg_fill] = r.number;
          reg_zone[reg_fill] = r.zone;
          reg_used[reg_fill] = 1'b0;
          hit = reg_fill;
          reg_fill++;
        end
      end
      CMD_MARK_USED, CMD_MARK_UNUSED, CMD_FIND_NUMBER: begin
        // The first slot holding the number wins.
        for (int i = 0; i < reg_fill; i++)
          if (hit < 0 && reg_number[i] == r.number) hit = i;
        if (hit >= 0 && r.cmd != CMD_FIND_NUMBER) begin
          reg_used[hit] = (r.cmd == CMD_MARK_USED);
          reg_pending = 2'd1;
        end
      end
      CMD_FIND_ZONE: begin
        for (int i = 0; i < reg_fill; i++)
          if (hit < 0 && (reg_zone[i] & r.zone) != 32'd0) hit = i;
      end
      CMD_FROM_MASK: begin
        // The highest selected position is the one reported.
        for (int i = 0; i < reg_fill; i++)
          if (r.imask[i]) hit = i;
      end
      CMD_CLEAR_USED: begin
        for (int i = 0; i < reg_fill; i++) reg_used[i] = 1'b0;
        reg_pending = r.mode ? 2'd2 : 2'd1;
      end
      CMD_COLLECT: begin
        for (int i = 0; i < reg_fill; i++) y.umask[i] = reg_used[i];
        y.pend = reg_pending;
        reg_pending = 2'd0;
      end
      default: begin
      end
    endcase
    if (hit >= 0) begin
      y.found = 1'b1;
      y.idx = hit[3:0];
      y.sbit = 16'd1 << hit;
    end
    if (r.cmd != CMD_COLLECT) y.pend = reg_pending;
    return y;
  endfunction

  // Offers one request, waits for it to be taken, records the reply it expects and maybe idles.
  task automatic drive_request(input registry_req_t r, input logic typed,
                               input registry_reply_t given);
    registry_reply_t y;
    in_valid <= 1'b1;
    command <= r.cmd;
    slot_number <= r.number;
    zone_mask <= r.zone;
    index_mask <= r.imask;
    reload_mode <= r.mode;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    y = registry_apply(r);
    expected_replies.push_back(typed ? given : y);
    requests_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Stimulus: reset, the directed table, then random request sequences.
  initial begin
    registry_req_t r;
    int n;
    in_valid <= 1'b0;
    command <= CMD_CLEAR;
    slot_number <= '0;
    zone_mask <= '0;
    index_mask <= '0;
    reload_mode <= 1'b0;
    rst <= 1'b1;
    reg_fill = 0;
    reg_pending = 2'd0;
    for (int i = 0; i < NSLOTS; i++) begin
      reg_number[i] = '0;
      reg_used[i] = 1'b0;
      reg_zone[i] = '0;
    end
    requests_sent = 0;
    failures = 0;
    quiet = 1'b0;
    long_hold_req = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      repeat (directed_rows[i].reps)
        drive_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].reply);

    while (requests_sent < TOTAL_REQUESTS) begin
      if (requests_sent >= QUIET_FROM) quiet = 1'b1;
      if (requests_sent >= HOLD_AT && requests_sent < HOLD_AT + 30) long_hold_req = 1'b1;
      // Within the pause window, let the block drain completely before carrying on.
      if (requests_sent >= PAUSE_AT && requests_sent < PAUSE_AT + 30) begin
        in_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge clk);
        @(posedge clk);
      end

      if ($urandom_range(0, 9) == 0) begin
        // Noise: any command code with arbitrary fields.
        r.cmd = 4'($urandom_range(0, 15));
        r.number = 16'($urandom);
        r.zone = $urandom;
        r.imask = 16'($urandom);
        r.mode = 1'($urandom);
        drive_request(r, 1'b0, ZERO_REPLY);
      end else begin
        // A well-formed sequence: usually a clear, then a fill, then operations on the numbers held.
        r = '0;
        if ($urandom_range(0, 3) != 0) begin
          r.cmd = CMD_CLEAR;
          r.mode = 1'($urandom);
          drive_request(r, 1'b0, ZERO_REPLY);
          appended_numbers.delete();
        end
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 10);
        repeat (n) begin
          r.cmd = CMD_APPEND;
          if (appended_numbers.size() > 0 && $urandom_range(0, 4) == 0)
            r.number = appended_numbers[$urandom_range(0, appended_numbers.size() - 1)];
          else
            r.number = 16'($urandom);
          r.zone = $urandom & $urandom;
          r.imask = 16'($urandom);
          r.mode = 1'($urandom);
          appended_numbers.push_back(r.number);
          drive_request(r, 1'b0, ZERO_REPLY);
        end
        repeat ($urandom_range(4, 16)) begin
          r.cmd = 4'($urandom_range(int'(CMD_MARK_USED), int'(CMD_COLLECT)));
          if (appended_numbers.size() > 0 && $urandom_range(0, 3) != 0)
            r.number = appended_numbers[$urandom_range(0, appended_numbers.size() - 1)];
          else
            r.number = 16'($urandom);
          case ($urandom_range(0, 3))
            0: r.zone = '0;
            1: r.zone = 32'd1 << $urandom_range(0, 31);
            default: r.zone = $urandom & $urandom;
          endcase
          r.imask = $urandom_range(0, 1) ? 16'($urandom) : 16'd1 << $urandom_range(0, 15);
          r.mode = 1'($urandom);
          drive_request(r, 1'b0, ZERO_REPLY);
        end
      end
    end

    // Wind down and give any stray reply time to show up.
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Reply side back-pressure: short random bursts, a long hold-off whenever one is requested.
  initial begin
    bit hold;
    int span;
    out_stall <= 1'b0;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 1'b1;
        span = HOLD_CYCLES;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        hold = 1'b1;
        span = $urandom_range(1, 8);
      end else begin
        hold = 1'b0;
        span = quiet ? 1 : $urandom_range(1, 16);
      end
      out_stall <= hold;
      repeat (span) @(posedge clk);
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  // Each reply taken is checked against the oldest outstanding prediction.
  always @(posedge clk) begin : reply_check
    registry_reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        $error("reply with no request outstanding");
        failures++;
      end else begin
        want = expected_replies.pop_front();
        compare_field("found", 32'(want.found), 32'(found));
        compare_field("slot_index", 32'(want.idx), 32'(slot_index));
        compare_field("slot_bit", 32'(want.sbit), 32'(slot_bit));
        compare_field("used_mask", 32'(want.umask), 32'(used_mask));
        compare_field("change_pending", 32'(want.pend), 32'(change_pending));
        compare_field("table_full", 32'(want.full), 32'(table_full));
      end
    end
  end

  // Watchdog for a hung block.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
design/srt_pkg.sv
design/srt_cell.sv
design/slot_registry_table.sv
dv/testbench.sv
